FILE: design/i2c_master_bit_engine_assert.svh
// assertion macros for the i2c master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define I2CBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/i2cbe_pkg.sv
// shared types, constants and line phase tables for the i2c master bit engine
`default_nettype none

package i2cbe_pkg;

  localparam int unsigned HoldW  = 16;
  localparam int unsigned PhaseW = 5;
  localparam logic [HoldW-1:0] HalfPeriodReset = 16'd50;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CHECK = 3'd4,
    CMD_SEND  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } line_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } res_t;

  function automatic logic [PhaseW-1:0] phase_total(input cmd_t cmd);
    logic [PhaseW-1:0] total;
    unique case (cmd)
      CMD_START: total = 5'd3;
      CMD_STOP:  total = 5'd4;
      CMD_WRITE: total = 5'd16;
      CMD_READ:  total = 5'd16;
      CMD_CHECK: total = 5'd3;
      CMD_SEND:  total = 5'd3;
      default:   total = 5'd0;
    endcase
    return total;
  endfunction

  // line levels set on the first tick of a phase
  function automatic line_t drive_phase(input cmd_t cmd, input logic [PhaseW-1:0] ph,
                                        input logic [7:0] sh, input line_t cur);
    line_t ln;
    ln = cur;
    unique case (cmd)
      CMD_START: begin
        ln.scl = (ph < 5'd2);
        ln.sda = (ph == 5'd0);
      end
      CMD_STOP: begin
        if (ph != 5'd0) ln.scl = (ph < 5'd3);
        ln.sda = (ph >= 5'd2);
      end
      CMD_WRITE: begin
        ln.scl = ~ph[0];
        ln.sda = sh[~ph[3:1]];
      end
      CMD_READ: begin
        ln.scl = ph[0];
        ln.sda = 1'b1;
      end
      CMD_CHECK: begin
        ln.scl = (ph < 5'd2);
        ln.sda = 1'b1;
      end
      CMD_SEND: begin
        if (ph != 5'd0) ln.scl = (ph == 5'd1);
        ln.sda = 1'b0;
      end
      default: ln = cur;
    endcase
    return ln;
  endfunction

endpackage

`default_nettype wire

FILE: design/i2cbe_apb_regs.sv
// apb configuration register holding the phase length
`default_nettype none

module i2cbe_apb_regs
  import i2cbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [HoldW-1:0]  half_period
);

  localparam logic [2:0] AddrHalfPeriod = 3'd0;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HalfPeriodReset;
    end else if (wr_en && paddr == AddrHalfPeriod) begin
      half_period <= pwdata[HoldW-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      AddrHalfPeriod: prdata = {{(32-HoldW){1'b0}}, half_period};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/i2cbe_seq.sv
// line sequencer: command state, phase and hold counters, line levels
`default_nettype none

module i2cbe_seq
  import i2cbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              cmd_valid,
  input  logic [2:0]        command,
  input  logic [7:0]        write_byte,
  input  logic              sda_level,
  input  logic [HoldW-1:0]  half_period,
  output res_t              res
);

  logic [PhaseW-1:0] phase_count, phase_count_next;
  logic [HoldW-1:0]  hold_count, hold_count_next;
  cmd_t              active_command, active_command_next;
  logic [7:0]        shift_data, shift_data_next;
  line_t             lines, lines_next;
  logic              ack_flag, ack_flag_next;
  logic              busy_flag, busy_flag_next;
  logic [7:0]        last_read, last_read_next;

  logic              start;
  cmd_t              cmd_e;
  logic [PhaseW-1:0] ph_e, ph_inc;
  logic [HoldW-1:0]  hold_e, hold_inc;
  logic [7:0]        sh_e;
  logic              done;

  always_comb begin
    start = !busy_flag && cmd_valid && (command <= 3'(CMD_SEND));
    cmd_e  = start ? cmd_t'(command) : active_command;
    ph_e   = start ? '0 : phase_count;
    hold_e = start ? '0 : hold_count;
    sh_e   = start ? ((cmd_t'(command) == CMD_WRITE) ? write_byte : 8'd0) : shift_data;

    active_command_next = cmd_e;
    phase_count_next    = ph_e;
    hold_count_next     = hold_e;
    shift_data_next     = sh_e;
    lines_next          = lines;
    ack_flag_next       = ack_flag;
    busy_flag_next      = busy_flag || start;
    last_read_next      = last_read;
    done                = 1'b0;
    hold_inc            = hold_e + 1'b1;
    ph_inc              = ph_e + 1'b1;

    if (busy_flag_next) begin
      if (hold_e == '0) lines_next = drive_phase(cmd_e, ph_e, sh_e, lines);
      if (hold_inc >= half_period) begin
        hold_count_next = '0;
        // sample on the last tick of a high phase
        if (cmd_e == CMD_READ && ph_e[0]) shift_data_next = {sh_e[6:0], sda_level};
        if (cmd_e == CMD_CHECK && ph_e == '0) ack_flag_next = !sda_level;
        if (ph_inc >= phase_total(cmd_e)) begin
          done             = 1'b1;
          busy_flag_next   = 1'b0;
          phase_count_next = '0;
          if (cmd_e == CMD_READ) begin
            lines_next.scl = 1'b0;
            last_read_next = shift_data_next;
          end
        end else begin
          phase_count_next = ph_inc;
        end
      end else begin
        hold_count_next = hold_inc;
      end
    end

    res.scl_level   = lines_next.scl;
    res.sda_release = lines_next.sda;
    res.busy_res    = busy_flag || start;
    res.done_res    = done;
    res.read_byte   = last_read_next;
    res.ack_seen    = ack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count    <= '0;
      hold_count     <= '0;
      active_command <= CMD_START;
      shift_data     <= '0;
      lines          <= '{scl: 1'b1, sda: 1'b1};
      ack_flag       <= 1'b0;
      busy_flag      <= 1'b0;
      last_read      <= '0;
    end else if (fire) begin
      phase_count    <= phase_count_next;
      hold_count     <= hold_count_next;
      active_command <= active_command_next;
      shift_data     <= shift_data_next;
      lines          <= lines_next;
      ack_flag       <= ack_flag_next;
      busy_flag      <= busy_flag_next;
      last_read      <= last_read_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/i2c_master_bit_engine.sv
// i2c master bit engine top: tick input register, sequencer, result register
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | cmd_valid command write_byte sda_level
//   out     | output    | out_valid/out_stall | scl_level sda_release busy_res done_res
//           |           |                     | read_byte ack_seen
//   apb     | input     | psel/penable        | paddr pwdata prdata
//
// one tick is taken per clock unless in_stall; results pass tick then result register
// sequencer state advances once per tick while the tick moves into the result register
// rst clears the valid flags and sequencer state, sets half_period to 50 and both lines released
// a stalled result holds the tick register; in_stall rises only then
`default_nettype none

module i2c_master_bit_engine
  import i2cbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd_valid,
  input  logic [2:0]  command,
  input  logic [7:0]  write_byte,
  input  logic        sda_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_release,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_byte,
  output logic        ack_seen,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "i2c_master_bit_engine_assert.svh"

  logic              in_full;
  logic              t_cmd_valid;
  logic [2:0]        t_command;
  logic [7:0]        t_write_byte;
  logic              t_sda_level;
  logic              out_free;
  logic              fire;
  logic [HoldW-1:0]  half_period;
  res_t              res;
  res_t              out_res;

  assign out_free = !out_valid || !out_stall;
  assign fire     = in_full && out_free;
  assign in_stall = in_full && !out_free;

  i2cbe_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .half_period (half_period)
  );

  i2cbe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .cmd_valid   (t_cmd_valid),
    .command     (t_command),
    .write_byte  (t_write_byte),
    .sda_level   (t_sda_level),
    .half_period (half_period),
    .res         (res)
  );

  // tick register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      t_cmd_valid  <= cmd_valid;
      t_command    <= command;
      t_write_byte <= write_byte;
      t_sda_level  <= sda_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign scl_level   = out_res.scl_level;
  assign sda_release = out_res.sda_release;
  assign busy_res    = out_res.busy_res;
  assign done_res    = out_res.done_res;
  assign read_byte   = out_res.read_byte;
  assign ack_seen    = out_res.ack_seen;

  `I2CBE_ASSERT_NOW(a_done_busy, out_valid && done_res, busy_res, "done without busy")
  `I2CBE_ASSERT_NEXT(a_fire_out, fire, out_valid, "processed tick produced no result")
  `I2CBE_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled needlessly")

endmodule

`default_nettype wire
